// ===== src/okset_pkg.sv =====
package okset_pkg;

	// default sizing
	localparam int KEY_BITS_DEF  = 10;
	localparam int WORD_BITS_DEF = 32;

	// limit register after reset
	localparam int MAX_KEY_RST = 1023;

	// request codes
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_PRED   = 2'd1;
	localparam logic [OP_W-1:0] OP_SUCC   = 2'd2;
	localparam logic [OP_W-1:0] OP_MEMBER = 2'd3;

	// result codes
	localparam int STAT_W = 2;
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REJECT    = 2'd2;

endpackage

// ===== src/okset_ram.sv =====
module okset_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/okset_split.sv =====
module okset_split #(
	parameter int KEY_BITS  = okset_pkg::KEY_BITS_DEF,
	parameter int WORD_BITS = okset_pkg::WORD_BITS_DEF
) (
	input  logic clk,
	input  logic [KEY_BITS-1:0] key,
	output logic [((((1 << KEY_BITS) + WORD_BITS - 1) / WORD_BITS) > 1 ?
		$clog2(((1 << KEY_BITS) + WORD_BITS - 1) / WORD_BITS) : 1) - 1:0] w,
	output logic [$clog2(WORD_BITS)-1:0] b,
	output logic [((((((1 << KEY_BITS) + WORD_BITS - 1) / WORD_BITS) + WORD_BITS - 1)
		/ WORD_BITS) > 1 ? $clog2(((((1 << KEY_BITS) + WORD_BITS - 1) / WORD_BITS)
		+ WORD_BITS - 1) / WORD_BITS) : 1) - 1:0] sidx,
	output logic [$clog2(WORD_BITS)-1:0] sbit
);

	localparam int NUM_WORDS = ((1 << KEY_BITS) + WORD_BITS - 1) / WORD_BITS;
	localparam int NUM_SUM   = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int SIW       = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int SQ_BITS   = WORD_BITS * WORD_BITS;
	// reciprocals scaled by 2^KEY_BITS, rounded down: estimate is low by at most one
	localparam int RECIP_W   = (1 << KEY_BITS) / WORD_BITS;
	localparam int RECIP_S   = (1 << KEY_BITS) / SQ_BITS;

	logic [2*KEY_BITS-1:0] prod_w;
	logic [2*KEY_BITS-1:0] prod_s;
	logic [KEY_BITS-1:0]   key_s1;
	logic [KEY_BITS-1:0]   qw_s1;
	logic [KEY_BITS-1:0]   qs_s1;
	logic [KEY_BITS:0]     rem_w;
	logic [KEY_BITS:0]     rem_s;
	logic [WIW-1:0]        w_s2;
	logic [BW-1:0]         b_s2;
	logic [SIW-1:0]        sidx_s2;
	logic [WIW-1:0]        w_s3;
	logic [BW-1:0]         b_s3;
	logic [SIW-1:0]        sidx_s3;
	logic [BW-1:0]         sbit_s3;

	// stage 1: quotient estimates by key / word size and key / word size squared
	assign prod_w = (2*KEY_BITS)'(key) * (2*KEY_BITS)'(RECIP_W);
	assign prod_s = (2*KEY_BITS)'(key) * (2*KEY_BITS)'(RECIP_S);

	always_ff @(posedge clk) begin
		key_s1 <= key;
		qw_s1  <= prod_w[2*KEY_BITS-1:KEY_BITS];
		qs_s1  <= prod_s[2*KEY_BITS-1:KEY_BITS];
	end

	// stage 2: remainders and one correction step each
	assign rem_w = (KEY_BITS+1)'(key_s1) - (KEY_BITS+1)'(qw_s1 * WORD_BITS);
	assign rem_s = (KEY_BITS+1)'(key_s1) - (KEY_BITS+1)'(qs_s1 * SQ_BITS);

	always_ff @(posedge clk) begin
		if (rem_w >= (KEY_BITS+1)'(WORD_BITS)) begin
			w_s2 <= WIW'(qw_s1 + 1'b1);
			b_s2 <= BW'(rem_w - (KEY_BITS+1)'(WORD_BITS));
		end else begin
			w_s2 <= WIW'(qw_s1);
			b_s2 <= BW'(rem_w);
		end
		if (int'(rem_s) >= SQ_BITS) begin
			sidx_s2 <= SIW'(qs_s1 + 1'b1);
		end else begin
			sidx_s2 <= SIW'(qs_s1);
		end
	end

	// stage 3: bit of the word within its summary word
	always_ff @(posedge clk) begin
		w_s3    <= w_s2;
		b_s3    <= b_s2;
		sidx_s3 <= sidx_s2;
		sbit_s3 <= BW'(w_s2 - WIW'(sidx_s2 * WORD_BITS));
	end

	assign w    = w_s3;
	assign b    = b_s3;
	assign sidx = sidx_s3;
	assign sbit = sbit_s3;

endmodule

// ===== src/ordered_key_set_pred_succ.sv =====
// channel   | signals                                  | transfer
// ----------+------------------------------------------+-------------------------------
// request   | start, opcode, key, busy                 | edge with start high, busy low
// result    | done, status, result_key                 | every cycle done is high
// limit reg | cfg_we, cfg_data                         | edge with cfg_we high
//
// Request to result, all reads on the one memory read port: the key splitter runs through S_SP1
// and S_SP2; a rejected insert is answered in S_WORD, a member test or a query answered in its own
// word in S_CHKW after the word read, an insert after its word then summary read-modify-write
// (S_CHKW, S_SUMI), a query leaving its word after a summary scan in S_SUM plus S_FIND on a hit.
// A new request is taken in the cycle the previous result is shown; results cannot be stalled.
// After reset a clearing pass over all NUM_WORDS + NUM_SUM words (33 by default) keeps busy high.
module ordered_key_set_pred_succ #(
	parameter int KEY_BITS  = okset_pkg::KEY_BITS_DEF,
	parameter int WORD_BITS = okset_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [okset_pkg::OP_W-1:0]   opcode,
	input  logic [KEY_BITS-1:0]          key,
	output logic                         busy,
	output logic                         done,
	output logic [okset_pkg::STAT_W-1:0] status,
	output logic [KEY_BITS-1:0]          result_key,
	input  logic                         cfg_we,
	input  logic [KEY_BITS-1:0]          cfg_data
);

	localparam int NUM_WORDS = ((1 << KEY_BITS) + WORD_BITS - 1) / WORD_BITS;
	localparam int NUM_SUM   = (NUM_WORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int TOTAL     = NUM_WORDS + NUM_SUM;
	localparam int AW        = $clog2(TOTAL);
	localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int SIW       = (NUM_SUM > 1) ? $clog2(NUM_SUM) : 1;
	localparam int BW        = $clog2(WORD_BITS);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_SP1   = 9'b000000100,
		S_SP2   = 9'b000001000,
		S_WORD  = 9'b000010000,
		S_CHKW  = 9'b000100000,
		S_SUMI  = 9'b001000000,
		S_SUM   = 9'b010000000,
		S_FIND  = 9'b100000000
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                clr_q;
	logic [KEY_BITS-1:0]          max_key_q;
	logic [okset_pkg::OP_W-1:0]   op_q;
	logic [KEY_BITS-1:0]          key_q;
	logic [SIW-1:0]               cur_q;
	logic                         first_q;
	logic [WIW-1:0]               j_q;
	logic                         done_q;
	logic [okset_pkg::STAT_W-1:0] status_q;
	logic [KEY_BITS-1:0]          result_key_q;

	logic [KEY_BITS-1:0]  split_key;
	logic [WIW-1:0]       w;
	logic [BW-1:0]        b;
	logic [SIW-1:0]       sidx;
	logic [BW-1:0]        sbit;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] rdata;

	logic                 is_succ;
	logic [WORD_BITS-1:0] bit_b;
	logic [WORD_BITS-1:0] bit_s;
	logic [WORD_BITS-1:0] up_b;
	logic [WORD_BITS-1:0] up_s;
	logic [WORD_BITS-1:0] word_m;
	logic [WORD_BITS-1:0] sum_m;
	logic [BW-1:0]        pos_word;
	logic [BW-1:0]        pos_sum;
	logic [AW-1:0]        sum_addr;
	logic [SIW-1:0]       nxt_cur;
	logic [WIW-1:0]       j_next;
	logic                 scan_end;

	// lowest set bit of a word
	function automatic logic [BW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
		logic [BW-1:0] p;
		p = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				p = BW'(i);
			end
		end
		return p;
	endfunction

	// highest set bit of a word
	function automatic logic [BW-1:0] highest_set(input logic [WORD_BITS-1:0] v);
		logic [BW-1:0] p;
		p = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) begin
				p = BW'(i);
			end
		end
		return p;
	endfunction

	// request key while idle, held key for the rest of the item
	assign split_key = (state_q == S_IDLE) ? key : key_q;

	// key to word index, bit, summary index and summary bit
	okset_split #(
		.KEY_BITS  (KEY_BITS),
		.WORD_BITS (WORD_BITS)
	) u_split (
		.clk  (clk),
		.key  (split_key),
		.w    (w),
		.b    (b),
		.sidx (sidx),
		.sbit (sbit)
	);

	// presence words followed by summary words
	okset_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (TOTAL)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// masks and bit searches on the word just read
	always_comb begin
		is_succ  = (op_q == okset_pkg::OP_SUCC);
		bit_b    = WORD_BITS'(1) << b;
		bit_s    = WORD_BITS'(1) << sbit;
		up_b     = {WORD_BITS{1'b1}} << b;
		up_s     = {WORD_BITS{1'b1}} << sbit;
		word_m   = is_succ ? (rdata & up_b) : (rdata & ~(up_b << 1));
		if (!first_q) begin
			sum_m = rdata;
		end else if (is_succ) begin
			sum_m = rdata & (up_s << 1);
		end else begin
			sum_m = rdata & ~up_s;
		end
		pos_word = is_succ ? lowest_set(word_m) : highest_set(word_m);
		pos_sum  = is_succ ? lowest_set(sum_m) : highest_set(sum_m);
		sum_addr = AW'(NUM_WORDS) + AW'(sidx);
		nxt_cur  = is_succ ? (cur_q + 1'b1) : (cur_q - 1'b1);
		j_next   = WIW'(cur_q * WORD_BITS + pos_sum);
		scan_end = is_succ ? (cur_q == SIW'(NUM_SUM - 1)) : (cur_q == '0);
	end

	// memory port: clearing pass, read-modify-write and scan reads
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = AW'(w);
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_CHKW: begin
				if (op_q == okset_pkg::OP_INSERT) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(w);
					mem_wdata = rdata | bit_b;
				end
				mem_raddr = sum_addr;
			end
			S_SUMI: begin
				mem_we    = 1'b1;
				mem_waddr = sum_addr;
				mem_wdata = rdata | bit_s;
			end
			S_SUM: begin
				if (sum_m != '0) begin
					mem_raddr = AW'(j_next);
				end else begin
					mem_raddr = AW'(NUM_WORDS) + AW'(nxt_cur);
				end
			end
			S_IDLE, S_SP1, S_SP2, S_WORD, S_FIND: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			max_key_q <= KEY_BITS'(okset_pkg::MAX_KEY_RST);
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_key_q <= cfg_data;
			end
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TOTAL - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						key_q   <= key;
						state_q <= S_SP1;
					end
				end
				S_SP1: begin
					state_q <= S_SP2;
				end
				S_SP2: begin
					state_q <= S_WORD;
				end
				S_WORD: begin
					if (op_q == okset_pkg::OP_INSERT && key_q > max_key_q) begin
						done_q       <= 1'b1;
						status_q     <= okset_pkg::STAT_REJECT;
						result_key_q <= key_q;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_CHKW;
					end
				end
				S_CHKW: begin
					if (op_q == okset_pkg::OP_INSERT) begin
						state_q <= S_SUMI;
					end else if (op_q == okset_pkg::OP_MEMBER) begin
						done_q       <= 1'b1;
						status_q     <= rdata[b] ? okset_pkg::STAT_OK
						                         : okset_pkg::STAT_NOT_FOUND;
						result_key_q <= key_q;
						state_q      <= S_IDLE;
					end else if (word_m != '0) begin
						done_q       <= 1'b1;
						status_q     <= okset_pkg::STAT_OK;
						result_key_q <= KEY_BITS'(w * WORD_BITS + pos_word);
						state_q      <= S_IDLE;
					end else begin
						cur_q   <= sidx;
						first_q <= 1'b1;
						state_q <= S_SUM;
					end
				end
				S_SUMI: begin
					done_q       <= 1'b1;
					status_q     <= okset_pkg::STAT_OK;
					result_key_q <= key_q;
					state_q      <= S_IDLE;
				end
				S_SUM: begin
					if (sum_m != '0) begin
						j_q     <= j_next;
						state_q <= S_FIND;
					end else if (scan_end) begin
						done_q       <= 1'b1;
						status_q     <= okset_pkg::STAT_NOT_FOUND;
						result_key_q <= key_q;
						state_q      <= S_IDLE;
					end else begin
						cur_q   <= nxt_cur;
						first_q <= 1'b0;
					end
				end
				S_FIND: begin
					done_q       <= 1'b1;
					status_q     <= okset_pkg::STAT_OK;
					result_key_q <= KEY_BITS'(j_q * WORD_BITS +
						(is_succ ? lowest_set(rdata) : highest_set(rdata)));
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign result_key = result_key_q;

endmodule

// ===== src/okset_chk.sv =====
module okset_chk #(
	parameter int KEY_BITS = okset_pkg::KEY_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic [okset_pkg::OP_W-1:0]   opcode,
	input logic [KEY_BITS-1:0]          key,
	input logic                         busy,
	input logic                         done,
	input logic [okset_pkg::STAT_W-1:0] status,
	input logic [KEY_BITS-1:0]          result_key
);

	logic [okset_pkg::OP_W-1:0] op_q;
	logic [KEY_BITS-1:0]        key_q;

	// remember the request in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= okset_pkg::OP_INSERT;
			key_q <= '0;
		end else if (start && !busy) begin
			op_q  <= opcode;
			key_q <= key;
		end
	end

	// a transfer in makes the block busy with no result in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("block not busy after request transfer");

	// a result is shown only once the block is free again
	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == okset_pkg::STAT_OK || status == okset_pkg::STAT_NOT_FOUND ||
			status == okset_pkg::STAT_REJECT))
		else $error("undefined status code");

	// insert and member test echo the key
	a_echo_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q != okset_pkg::OP_PRED && op_q != okset_pkg::OP_SUCC)
		|-> (result_key == key_q))
		else $error("key not echoed");

	// rejection only for an insert
	a_reject_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == okset_pkg::STAT_REJECT) |-> (op_q == okset_pkg::OP_INSERT))
		else $error("rejection on a query");

endmodule

bind ordered_key_set_pred_succ okset_chk #(
	.KEY_BITS (KEY_BITS)
) u_okset_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.opcode     (opcode),
	.key        (key),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.result_key (result_key)
);
